// File: sv/wfps_pkg.sv
// Package for the wall-follow PID steering block.
// Holds field widths, register indexes, register reset values and sizing constants.
// No dependencies.
package wfps_pkg;

    // Sizing of the state and of the IR sweep
    localparam int SUM_WIDTH  = 16;
    localparam int IR_SAMPLES = 20;

    // Transaction field widths
    localparam int DIST_W  = 9;
    localparam int IR_W    = 5;
    localparam int SPEED_W = 9;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Register field widths
    localparam int SET_POINT_W = 5;
    localparam int GAIN_W      = 7;
    localparam int BASE_W      = 8;
    localparam int STOP_W      = 8;
    localparam int LIMIT_W     = 7;

    // Datapath widths
    localparam int ERR_W      = 6;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int P_TERM_W   = GAIN_W + ERR_W;
    localparam int I_TERM_W   = GAIN_W + SUM_WIDTH;
    localparam int D_TERM_W   = GAIN_W + DIFF_W;
    localparam int CORR_SUM_W = I_TERM_W + 1;
    localparam int CORR_W     = LIMIT_W + 1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SET_POINT        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P           = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I           = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D           = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_SPEED       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_DISTANCE    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CORRECTION_LIMIT = 3'd6;

    // Register reset values
    localparam logic [SET_POINT_W-1:0]   RST_SET_POINT        = 5'd12;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_P           = -7'sd8;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_I           = -7'sd3;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_D           = -7'sd3;
    localparam logic [BASE_W-1:0]        RST_BASE_SPEED       = 8'd86;
    localparam logic [STOP_W-1:0]        RST_STOP_DISTANCE    = 8'd5;
    localparam logic [LIMIT_W-1:0]       RST_CORRECTION_LIMIT = 7'd30;

endpackage

// File: sv/wfps_if.sv
// Channel interfaces for the wall-follow PID steering block.
// Sensor tick channel and wheel drive channel; widths from wfps_pkg.
interface wfps_tick_if;
    logic                         valid;
    logic                         ready;
    logic [wfps_pkg::DIST_W-1:0]  front_distance;
    logic [wfps_pkg::IR_W-1:0]    ir_count;

    modport source (output valid, output front_distance, output ir_count, input ready);
    modport sink   (input valid, input front_distance, input ir_count, output ready);
endinterface

interface wfps_drive_if;
    logic                               valid;
    logic                               ready;
    logic signed [wfps_pkg::SPEED_W-1:0] left_speed;
    logic signed [wfps_pkg::SPEED_W-1:0] right_speed;
    logic                               stopped;

    modport source (output valid, output left_speed, output right_speed, output stopped,
                    input ready);
    modport sink   (input valid, input left_speed, input right_speed, input stopped,
                    output ready);
endinterface

// File: sv/wall_follow_pid_steering.sv
// Wall-follow PID steering: one control tick in, one pair of wheel commands out.
// Depends on wfps_pkg and the channel interfaces in wfps_if.sv.
//
//   channel   dir  fields                                  handshake
//   tick      in   front_distance[9], ir_count[5]          valid/ready
//   drive     out  left_speed[9] s, right_speed[9] s,      valid/ready
//                  stopped[1]
//   write_*   in   write_index[3], write_data[8]           write_en, no wait
//
// Three register stages: input, PID terms, wheel commands. A tick passes through
// them in that order to drive; a new tick is taken every cycle unless drive.ready
// is low with all three stages full. last_error and error_sum update in the input
// stage as its tick advances, so each tick sees the PID state left by the one before.
// Reset clears the pipeline, the PID state and restores the register defaults.
// drive.ready low holds only full stages; tick.ready drops only when all are full.
module wall_follow_pid_steering
(
    input  logic                              clk,
    input  logic                              rst_n,
    wfps_tick_if.sink                         tick,
    wfps_drive_if.source                      drive,
    input  logic                              write_en,
    input  logic [wfps_pkg::CFG_INDEX_W-1:0]  write_index,
    input  logic [wfps_pkg::CFG_DATA_W-1:0]   write_data
);

    localparam logic signed [wfps_pkg::SUM_WIDTH-1:0] SUM_MAX =
        {1'b0, {(wfps_pkg::SUM_WIDTH-1){1'b1}}};
    localparam logic signed [wfps_pkg::SUM_WIDTH-1:0] SUM_MIN =
        {1'b1, {(wfps_pkg::SUM_WIDTH-1){1'b0}}};
    localparam logic signed [wfps_pkg::SPEED_W-1:0] SPEED_MAX =
        {1'b0, {(wfps_pkg::SPEED_W-1){1'b1}}};
    localparam logic signed [wfps_pkg::SPEED_W-1:0] SPEED_MIN =
        {1'b1, {(wfps_pkg::SPEED_W-1){1'b0}}};
    localparam logic [wfps_pkg::IR_W-1:0] IR_MAX = wfps_pkg::IR_W'(wfps_pkg::IR_SAMPLES);

    typedef struct packed {
        logic                                  stop;
        logic                                  err_neg;
        logic                                  err_zero;
        logic signed [wfps_pkg::P_TERM_W-1:0]  p_term;
        logic signed [wfps_pkg::I_TERM_W-1:0]  i_term;
        logic signed [wfps_pkg::D_TERM_W-1:0]  d_term;
    } terms_t;

    // Saturate a one-bit-wider sum to the wheel command range
    function automatic logic signed [wfps_pkg::SPEED_W-1:0] sat_speed(
        input logic signed [wfps_pkg::SPEED_W:0] v);
        logic signed [wfps_pkg::SPEED_W-1:0] r;
        if (v[wfps_pkg::SPEED_W] != v[wfps_pkg::SPEED_W-1])
            r = v[wfps_pkg::SPEED_W] ? SPEED_MIN : SPEED_MAX;
        else
            r = v[wfps_pkg::SPEED_W-1:0];
        return r;
    endfunction

    // Configuration registers
    logic [wfps_pkg::SET_POINT_W-1:0]   set_point_reg;
    logic signed [wfps_pkg::GAIN_W-1:0] gain_p_reg;
    logic signed [wfps_pkg::GAIN_W-1:0] gain_i_reg;
    logic signed [wfps_pkg::GAIN_W-1:0] gain_d_reg;
    logic [wfps_pkg::BASE_W-1:0]        base_speed_reg;
    logic [wfps_pkg::STOP_W-1:0]        stop_distance_reg;
    logic [wfps_pkg::LIMIT_W-1:0]       correction_limit_reg;

    // PID state
    logic signed [wfps_pkg::ERR_W-1:0]     last_error_reg;
    logic signed [wfps_pkg::ERR_W-1:0]     last_error_next;
    logic signed [wfps_pkg::SUM_WIDTH-1:0] error_sum_reg;
    logic signed [wfps_pkg::SUM_WIDTH-1:0] error_sum_next;

    // Pipeline registers
    logic                           v0_reg;
    logic [wfps_pkg::DIST_W-1:0]    dist0_reg;
    logic [wfps_pkg::IR_W-1:0]      ir0_reg;
    logic                           v1_reg;
    terms_t                         terms1_reg;
    terms_t                         terms1_next;
    logic                           v2_reg;
    logic signed [wfps_pkg::SPEED_W-1:0] left2_reg;
    logic signed [wfps_pkg::SPEED_W-1:0] left2_next;
    logic signed [wfps_pkg::SPEED_W-1:0] right2_reg;
    logic signed [wfps_pkg::SPEED_W-1:0] right2_next;
    logic                           stop2_reg;

    // Stage enables
    logic en0;
    logic en1;
    logic en2;
    logic adv0;

    // Stage A signals
    logic                                  stop_a;
    logic [wfps_pkg::IR_W-1:0]             ir_sat_a;
    logic signed [wfps_pkg::ERR_W-1:0]     err_a;
    logic                                  err_pos_a;
    logic                                  err_neg_a;
    logic                                  last_pos_a;
    logic                                  last_neg_a;
    logic                                  clear_a;
    logic signed [wfps_pkg::SUM_WIDTH-1:0] sum_cur_a;
    logic signed [wfps_pkg::SUM_WIDTH:0]   sum_wide_a;
    logic signed [wfps_pkg::SUM_WIDTH-1:0] sum_sat_a;
    logic signed [wfps_pkg::DIFF_W-1:0]    diff_a;

    // Stage B signals
    logic signed [wfps_pkg::CORR_SUM_W-1:0] corr_sum_b;
    logic signed [wfps_pkg::CORR_SUM_W-1:0] lim_b;
    logic signed [wfps_pkg::CORR_SUM_W-1:0] corr_clamp_b;
    logic signed [wfps_pkg::CORR_W-1:0]     corr_b;
    logic signed [wfps_pkg::SPEED_W:0]      base_b;
    logic signed [wfps_pkg::SPEED_W:0]      left_wide_b;
    logic signed [wfps_pkg::SPEED_W:0]      right_wide_b;

    // Handshake: each stage loads when empty or when the next one loads
    assign en2  = !v2_reg || drive.ready;
    assign en1  = !v1_reg || en2;
    assign en0  = !v0_reg || en1;
    assign adv0 = v0_reg && en1;

    assign tick.ready        = en0;
    assign drive.valid       = v2_reg;
    assign drive.left_speed  = left2_reg;
    assign drive.right_speed = right2_reg;
    assign drive.stopped     = stop2_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_point_reg        <= wfps_pkg::RST_SET_POINT;
            gain_p_reg           <= wfps_pkg::RST_GAIN_P;
            gain_i_reg           <= wfps_pkg::RST_GAIN_I;
            gain_d_reg           <= wfps_pkg::RST_GAIN_D;
            base_speed_reg       <= wfps_pkg::RST_BASE_SPEED;
            stop_distance_reg    <= wfps_pkg::RST_STOP_DISTANCE;
            correction_limit_reg <= wfps_pkg::RST_CORRECTION_LIMIT;
        end
        else if (write_en)
        begin
            unique case (write_index)
                wfps_pkg::REG_SET_POINT:
                    set_point_reg <= write_data[wfps_pkg::SET_POINT_W-1:0];
                wfps_pkg::REG_GAIN_P:
                    gain_p_reg <= write_data[wfps_pkg::GAIN_W-1:0];
                wfps_pkg::REG_GAIN_I:
                    gain_i_reg <= write_data[wfps_pkg::GAIN_W-1:0];
                wfps_pkg::REG_GAIN_D:
                    gain_d_reg <= write_data[wfps_pkg::GAIN_W-1:0];
                wfps_pkg::REG_BASE_SPEED:
                    base_speed_reg <= write_data[wfps_pkg::BASE_W-1:0];
                wfps_pkg::REG_STOP_DISTANCE:
                    stop_distance_reg <= write_data[wfps_pkg::STOP_W-1:0];
                wfps_pkg::REG_CORRECTION_LIMIT:
                    correction_limit_reg <= write_data[wfps_pkg::LIMIT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Stage A: error, sign-change clear, integral update and PID products
    always_comb
    begin
        stop_a    = dist0_reg <= {1'b0, stop_distance_reg};
        ir_sat_a  = (ir0_reg > IR_MAX) ? IR_MAX : ir0_reg;
        err_a     = $signed({1'b0, set_point_reg}) - $signed({1'b0, ir_sat_a});
        err_neg_a = err_a[wfps_pkg::ERR_W-1];
        err_pos_a = !err_neg_a && (err_a != '0);
        last_neg_a = last_error_reg[wfps_pkg::ERR_W-1];
        last_pos_a = !last_neg_a && (last_error_reg != '0);
        clear_a   = (last_pos_a && !err_pos_a) || (last_neg_a && !err_neg_a);
        sum_cur_a = clear_a ? '0 : error_sum_reg;
        diff_a    = wfps_pkg::DIFF_W'(err_a) - wfps_pkg::DIFF_W'(last_error_reg);

        // Saturating accumulate
        sum_wide_a = (wfps_pkg::SUM_WIDTH+1)'(sum_cur_a) + (wfps_pkg::SUM_WIDTH+1)'(err_a);
        if (sum_wide_a[wfps_pkg::SUM_WIDTH] != sum_wide_a[wfps_pkg::SUM_WIDTH-1])
            sum_sat_a = sum_wide_a[wfps_pkg::SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        else
            sum_sat_a = sum_wide_a[wfps_pkg::SUM_WIDTH-1:0];

        // Hold the state on a stopped tick; a zero error does not accumulate
        last_error_next = last_error_reg;
        error_sum_next  = error_sum_reg;
        if (adv0 && !stop_a)
        begin
            last_error_next = err_a;
            error_sum_next  = (err_a == '0) ? sum_cur_a : sum_sat_a;
        end

        terms1_next.stop     = stop_a;
        terms1_next.err_neg  = err_neg_a;
        terms1_next.err_zero = (err_a == '0);
        terms1_next.p_term   = wfps_pkg::P_TERM_W'(gain_p_reg) * wfps_pkg::P_TERM_W'(err_a);
        terms1_next.i_term   = wfps_pkg::I_TERM_W'(gain_i_reg) * wfps_pkg::I_TERM_W'(sum_cur_a);
        terms1_next.d_term   = wfps_pkg::D_TERM_W'(gain_d_reg) * wfps_pkg::D_TERM_W'(diff_a);
    end

    // Stage B: sum, clamp and steer one wheel
    always_comb
    begin
        corr_sum_b = wfps_pkg::CORR_SUM_W'(terms1_reg.p_term)
                   + wfps_pkg::CORR_SUM_W'(terms1_reg.i_term)
                   + wfps_pkg::CORR_SUM_W'(terms1_reg.d_term);
        lim_b = $signed({{(wfps_pkg::CORR_SUM_W-wfps_pkg::LIMIT_W){1'b0}},
                         correction_limit_reg});
        if (corr_sum_b > lim_b)
            corr_clamp_b = lim_b;
        else if (corr_sum_b < -lim_b)
            corr_clamp_b = -lim_b;
        else
            corr_clamp_b = corr_sum_b;
        corr_b = corr_clamp_b[wfps_pkg::CORR_W-1:0];

        base_b       = $signed({2'b00, base_speed_reg});
        left_wide_b  = base_b - (wfps_pkg::SPEED_W+1)'(corr_b);
        right_wide_b = base_b + (wfps_pkg::SPEED_W+1)'(corr_b);

        if (terms1_reg.stop)
        begin
            left2_next  = '0;
            right2_next = '0;
        end
        else if (terms1_reg.err_zero)
        begin
            left2_next  = base_b[wfps_pkg::SPEED_W-1:0];
            right2_next = base_b[wfps_pkg::SPEED_W-1:0];
        end
        else if (terms1_reg.err_neg)
        begin
            left2_next  = sat_speed(left_wide_b);
            right2_next = base_b[wfps_pkg::SPEED_W-1:0];
        end
        else
        begin
            left2_next  = base_b[wfps_pkg::SPEED_W-1:0];
            right2_next = sat_speed(right_wide_b);
        end
    end

    // Control state: valid bits and PID state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            last_error_reg <= '0;
            error_sum_reg  <= '0;
        end
        else
        begin
            if (en0)
                v0_reg <= tick.valid;
            if (en1)
                v1_reg <= v0_reg;
            if (en2)
                v2_reg <= v1_reg;
            last_error_reg <= last_error_next;
            error_sum_reg  <= error_sum_next;
        end
    end

    // Payload registers: advance with their stage
    always_ff @(posedge clk)
    begin
        if (en0 && tick.valid)
        begin
            dist0_reg <= tick.front_distance;
            ir0_reg   <= tick.ir_count;
        end
        if (adv0)
            terms1_reg <= terms1_next;
        if (en2 && v1_reg)
        begin
            left2_reg  <= left2_next;
            right2_reg <= right2_next;
            stop2_reg  <= terms1_reg.stop;
        end
    end

endmodule

// File: sv/wfps_checker.sv
// Port-level checker for the wall-follow PID steering block, with its bind.
// Depends on wfps_pkg; attaches to wall_follow_pid_steering.
module wfps_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                drive_valid,
    input logic                                drive_ready,
    input logic signed [wfps_pkg::SPEED_W-1:0] left_speed,
    input logic signed [wfps_pkg::SPEED_W-1:0] right_speed,
    input logic                                stopped
);

    // A stopped transaction drives both wheels to zero
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid && stopped |-> (left_speed == '0) && (right_speed == '0))
        else $error("stopped transaction with nonzero wheel speed");

    // One wheel always runs at base speed, so at least one command is non-negative
    a_one_forward: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid && !stopped |->
            !left_speed[wfps_pkg::SPEED_W-1] || !right_speed[wfps_pkg::SPEED_W-1])
        else $error("both wheels reversing");

    // Hold a stalled transaction
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid && !drive_ready |=>
            drive_valid && $stable(left_speed) && $stable(right_speed) && $stable(stopped))
        else $error("stalled transaction changed");

    // Come out of reset with no result pending
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !drive_valid)
        else $error("result pending right after reset");

endmodule

bind wall_follow_pid_steering wfps_checker u_wfps_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .drive_valid (drive.valid),
    .drive_ready (drive.ready),
    .left_speed  (drive.left_speed),
    .right_speed (drive.right_speed),
    .stopped     (drive.stopped)
);

// File: tb/sv/steering_checker.sv
`timescale 1ns / 1ps
// Scoreboard for wall_follow_pid_steering: mirrors register writes, predicts the
// wheel commands of every accepted tick and compares them with the drive channel.
// Depends on wfps_pkg and the channel interfaces in wfps_if.sv.
module steering_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    wfps_tick_if                              tick,
    wfps_drive_if                             drive,
    input  logic                              write_en,
    input  logic [wfps_pkg::CFG_INDEX_W-1:0]  write_index,
    input  logic [wfps_pkg::CFG_DATA_W-1:0]   write_data,
    output int                                mismatches,
    output int                                pending
);

    typedef struct packed {
        logic signed [wfps_pkg::SPEED_W-1:0] left_speed;
        logic signed [wfps_pkg::SPEED_W-1:0] right_speed;
        logic                                stopped;
    } wheel_cmd_t;

    // Shadow copy of the register file
    logic [wfps_pkg::SET_POINT_W-1:0]   set_point;
    logic signed [wfps_pkg::GAIN_W-1:0] gain_p;
    logic signed [wfps_pkg::GAIN_W-1:0] gain_i;
    logic signed [wfps_pkg::GAIN_W-1:0] gain_d;
    logic [wfps_pkg::BASE_W-1:0]        base_speed;
    logic [wfps_pkg::STOP_W-1:0]        stop_distance;
    logic [wfps_pkg::LIMIT_W-1:0]       correction_limit;

    // Controller state
    logic signed [wfps_pkg::ERR_W-1:0]     last_err;
    logic signed [wfps_pkg::SUM_WIDTH-1:0] err_acc;

    wheel_cmd_t expected_cmds[$];

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // One control tick: returns the wheel commands and advances the PID state
    function automatic wheel_cmd_t steer_tick(logic [wfps_pkg::DIST_W-1:0] distance,
                                              logic [wfps_pkg::IR_W-1:0] ir);
        wheel_cmd_t cmd;
        int         ir_hits;
        int         err;
        int         diff;
        longint     corr;
        longint     left;
        longint     right;
        longint     acc_hi;
        longint     acc_lo;
        acc_hi = (longint'(1) <<< (wfps_pkg::SUM_WIDTH - 1)) - 1;
        acc_lo = -acc_hi - 1;
        cmd = '0;
        // Obstacle ahead: stop and keep the state
        if (distance <= stop_distance) begin
            cmd.stopped = 1'b1;
            return cmd;
        end
        ir_hits = (ir > wfps_pkg::IR_SAMPLES) ? wfps_pkg::IR_SAMPLES : int'(ir);
        err = int'(set_point) - ir_hits;
        // Drop the integral when the error crosses or touches zero from either side
        if ((last_err > 0 && err <= 0) || (last_err < 0 && err >= 0))
            err_acc = '0;
        diff = err - int'(last_err);
        last_err = wfps_pkg::ERR_W'(err);
        left = longint'(base_speed);
        right = longint'(base_speed);
        if (err != 0) begin
            corr = longint'(gain_p) * err + longint'(gain_i) * longint'(err_acc)
                 + longint'(gain_d) * diff;
            corr = clamp(corr, -longint'(correction_limit), longint'(correction_limit));
            err_acc = wfps_pkg::SUM_WIDTH'(clamp(longint'(err_acc) + err, acc_lo, acc_hi));
            if (err < 0)
                left = longint'(base_speed) - corr;
            else
                right = longint'(base_speed) + corr;
        end
        cmd.left_speed = wfps_pkg::SPEED_W'(clamp(left, -256, 255));
        cmd.right_speed = wfps_pkg::SPEED_W'(clamp(right, -256, 255));
        return cmd;
    endfunction

    // Track writes, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        wheel_cmd_t want;
        if (!rst_n)
        begin
            set_point = wfps_pkg::RST_SET_POINT;
            gain_p = wfps_pkg::RST_GAIN_P;
            gain_i = wfps_pkg::RST_GAIN_I;
            gain_d = wfps_pkg::RST_GAIN_D;
            base_speed = wfps_pkg::RST_BASE_SPEED;
            stop_distance = wfps_pkg::RST_STOP_DISTANCE;
            correction_limit = wfps_pkg::RST_CORRECTION_LIMIT;
            last_err = '0;
            err_acc = '0;
            mismatches = 0;
            expected_cmds.delete();
        end
        else
        begin
            if (write_en)
            begin
                case (write_index)
                    wfps_pkg::REG_SET_POINT:
                        set_point = write_data[wfps_pkg::SET_POINT_W-1:0];
                    wfps_pkg::REG_GAIN_P:
                        gain_p = write_data[wfps_pkg::GAIN_W-1:0];
                    wfps_pkg::REG_GAIN_I:
                        gain_i = write_data[wfps_pkg::GAIN_W-1:0];
                    wfps_pkg::REG_GAIN_D:
                        gain_d = write_data[wfps_pkg::GAIN_W-1:0];
                    wfps_pkg::REG_BASE_SPEED:
                        base_speed = write_data[wfps_pkg::BASE_W-1:0];
                    wfps_pkg::REG_STOP_DISTANCE:
                        stop_distance = write_data[wfps_pkg::STOP_W-1:0];
                    wfps_pkg::REG_CORRECTION_LIMIT:
                        correction_limit = write_data[wfps_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (tick.valid && tick.ready)
                expected_cmds.push_back(steer_tick(tick.front_distance, tick.ir_count));
            if (drive.valid && drive.ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: drive transaction with nothing expected: %s %0d %0d %0b",
                                 $realtime, "left/right/stopped",
                                 drive.left_speed, drive.right_speed, drive.stopped);
                    mismatches++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (drive.left_speed !== want.left_speed
                        || drive.right_speed !== want.right_speed
                        || drive.stopped !== want.stopped)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: drive mismatch: expected left %0d right %0d ",
                                      "stopped %0b, got left %0d right %0d stopped %0b"},
                                     $realtime, want.left_speed, want.right_speed,
                                     want.stopped, drive.left_speed, drive.right_speed,
                                     drive.stopped);
                        mismatches++;
                    end
                end
            end
        end
        pending = expected_cmds.size();
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the wall_follow_pid_steering testbench: clock, reset, register writes,
// tick stimulus and drive back-pressure. Checking lives in steering_checker.
// Depends on wfps_pkg, wfps_if.sv, the block itself and steering_checker.sv.
module tb_top;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_TICKS   = 58;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             write_en;
    logic [wfps_pkg::CFG_INDEX_W-1:0] write_index;
    logic [wfps_pkg::CFG_DATA_W-1:0]  write_data;
    int                               mismatches;
    int                               pending;

    // No-idle mode for both channels, set for each phase
    bit steady = 1'b0;
    int cur_set_point = wfps_pkg::RST_SET_POINT;
    int cur_stop = wfps_pkg::RST_STOP_DISTANCE;

    wfps_tick_if  tick();
    wfps_drive_if drive();

    wall_follow_pid_steering i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .drive       (drive),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data)
    );

    steering_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .drive       (drive),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always #2 clk = ~clk;

    // Hard stop on a hang
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    // Drive channel: random stall before each result
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                @(negedge clk);
                drive.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            drive.ready <= 1'b1;
            do @(posedge clk); while (!(drive.valid && drive.ready));
        end
    end

    function automatic int pick(int lo, int hi);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            default: return lo + int'($urandom_range(hi - lo, 0));
        endcase
    endfunction

    // Present one tick after a random gap and hold it until taken
    task automatic send_tick(int distance, int ir);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            @(negedge clk);
            tick.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        tick.valid <= 1'b1;
        tick.front_distance <= wfps_pkg::DIST_W'(distance);
        tick.ir_count <= wfps_pkg::IR_W'(ir);
        do @(posedge clk); while (!tick.ready);
    endtask

    // Let the pipeline empty so the registers can be changed
    task automatic drain();
        @(negedge clk);
        tick.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(logic [wfps_pkg::CFG_INDEX_W-1:0] idx, int data);
        @(negedge clk);
        write_en <= 1'b1;
        write_index <= idx;
        write_data <= wfps_pkg::CFG_DATA_W'(data);
    endtask

    // Write the whole register file; gains are given as signed values
    task automatic set_regs(int sp, int kp, int ki, int kd, int base, int stop, int lim);
        drain();
        write_reg(wfps_pkg::REG_SET_POINT, sp);
        write_reg(wfps_pkg::REG_GAIN_P, kp);
        write_reg(wfps_pkg::REG_GAIN_I, ki);
        write_reg(wfps_pkg::REG_GAIN_D, kd);
        write_reg(wfps_pkg::REG_BASE_SPEED, base);
        write_reg(wfps_pkg::REG_STOP_DISTANCE, stop);
        write_reg(wfps_pkg::REG_CORRECTION_LIMIT, lim);
        @(negedge clk);
        write_en <= 1'b0;
        cur_set_point = sp & 31;
        cur_stop = stop & 255;
    endtask

    task automatic random_tick();
        int distance;
        int ir;
        case ($urandom_range(0, 9))
            0:       distance = $urandom_range(cur_stop, 0);
            1:       distance = $urandom_range(511, 0);
            default: distance = $urandom_range(511, cur_stop + 1);
        endcase
        case ($urandom_range(0, 7))
            0:       ir = $urandom_range(31, 21);
            1:       ir = (cur_set_point <= wfps_pkg::IR_SAMPLES) ? cur_set_point
                                                                  : wfps_pkg::IR_SAMPLES;
            default: ir = $urandom_range(wfps_pkg::IR_SAMPLES, 0);
        endcase
        send_tick(distance, ir);
    endtask

    initial
    begin
        tick.valid = 1'b0;
        tick.front_distance = '0;
        tick.ir_count = '0;
        drive.ready = 1'b0;
        write_en = 1'b0;
        write_index = '0;
        write_data = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: stop boundary, both error signs, sign changes, zero error,
        // excess IR count, state kept across a stop
        send_tick(0, 0);
        send_tick(5, 20);
        send_tick(6, 20);
        send_tick(511, 20);
        send_tick(300, 0);
        send_tick(300, 12);
        send_tick(300, 12);
        send_tick(300, 13);
        send_tick(300, 31);
        send_tick(300, 21);
        send_tick(4, 0);
        send_tick(300, 11);
        send_tick(300, 5);

        // Upper extremes: wheel speed saturates high, stop distance zero
        set_regs(31, 63, 63, 63, 255, 0, 127);
        send_tick(1, 0);
        send_tick(0, 0);
        send_tick(256, 31);
        send_tick(511, 16);

        // Lower extremes: negative gains, zero base speed, largest stop distance
        set_regs(0, -64, -64, -64, 0, 255, 127);
        send_tick(255, 20);
        send_tick(256, 20);
        send_tick(400, 31);
        set_regs(0, -64, -64, -64, 0, 255, 0);
        send_tick(511, 20);
        send_tick(300, 0);

        // Long integral build-up of both signs, no idling
        steady = 1'b1;
        set_regs(31, 1, 1, 1, 100, 0, 64);
        repeat (100) send_tick(511, 0);
        set_regs(0, 1, 1, 1, 100, 0, 64);
        repeat (25) send_tick(511, 20);
        repeat (25) send_tick(511, 31);

        // Random settings and random ticks
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            steady = ($urandom_range(0, 3) == 0);
            set_regs(pick(0, 31) | ($urandom_range(7, 0) << 5),
                     ($urandom_range(0, 2) == 0) ? pick(-64, 63) : $urandom_range(255, 0),
                     ($urandom_range(0, 2) == 0) ? pick(-64, 63) : $urandom_range(255, 0),
                     ($urandom_range(0, 2) == 0) ? pick(-64, 63) : $urandom_range(255, 0),
                     pick(0, 255),
                     ($urandom_range(0, 2) == 0) ? pick(0, 255) : $urandom_range(40, 0),
                     pick(0, 127) | ($urandom_range(1, 0) << 7));
            repeat (PHASE_TICKS) random_tick();
        end

        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
sv/wfps_pkg.sv
sv/wfps_if.sv
sv/wall_follow_pid_steering.sv
sv/wfps_checker.sv
tb/sv/steering_checker.sv
tb/sv/tb_top.sv
